// ===== hw/rtl/cda_pkg.sv =====
package cda_pkg;

   // Operation codes carried in a request.
   localparam logic [1:0] OP_ADD_DAYS   = 2'd0;
   localparam logic [1:0] OP_ADD_WEEKS  = 2'd1;
   localparam logic [1:0] OP_ADD_MONTHS = 2'd2;

   // Status codes returned with a result.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_DATE  = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   localparam int DAY_WIDTH   = 5;
   localparam int MONTH_WIDTH = 4;
   localparam int COUNT_WIDTH = 12;
   localparam int YEAR_BITS   = 14;
   // Largest day-step count is seven times the largest count.
   localparam int STEPS_WIDTH = 15;
   localparam int REM400_WIDTH = 9;
   localparam int REM100_WIDTH = 7;

   localparam logic [MONTH_WIDTH-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_WIDTH-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_WIDTH-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [1:0]             op;
      logic [COUNT_WIDTH-1:0] count;
      logic [DAY_WIDTH-1:0]   start_day;
      logic [MONTH_WIDTH-1:0] start_month;
      logic [YEAR_BITS-1:0]   start_year;
   } req_type;

   typedef struct packed {
      logic [DAY_WIDTH-1:0]   end_day;
      logic [MONTH_WIDTH-1:0] end_month;
      logic [YEAR_BITS-1:0]   end_year;
      logic [1:0]             status;
   } rsp_type;

   typedef struct packed {
      logic                 year_over;
      logic [DAY_WIDTH-1:0] month_len;
   } cda_step_status_type;

   function automatic logic [DAY_WIDTH-1:0] month_days(input logic [MONTH_WIDTH-1:0] month,
                                                       input logic leap);
      logic [DAY_WIDTH-1:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== hw/rtl/calendar_date_adder.sv =====
// Channel   Ports                    Direction  Handshake
// request   start, busy, req_data    in         taken when start is high and busy is low
// result    rsp_valid, rsp_data      out        one-cycle strobe, no back-pressure
//
// A request runs through ST_REDUCE, ST_SPLIT and ST_CHECK, then takes N single-day or
// single-month steps in ST_RUN, N being count, or seven times count for weeks, at most 28665;
// a bad date skips ST_RUN and its steps, saturation stops early.
// The shared step unit advances the date by one day or one month per cycle; the year
// remainder modulo 400 is found first by repeated subtraction. Reset clears the sequencer and
// the result strobe. busy is high from the cycle after a request is taken until the strobe.
module calendar_date_adder #(
   parameter int COUNT_MAX = 4095,
   parameter int YEAR_MAX  = 9999
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cda_pkg::req_type req_data,
   output logic             rsp_valid,
   output cda_pkg::rsp_type rsp_data
);
   import cda_pkg::*;

   localparam int YearNeed  = $clog2(YEAR_MAX + 1);
   localparam int YearWidth = (YearNeed > YEAR_BITS) ? YearNeed : YEAR_BITS;
   localparam logic [YearWidth-1:0] YearLimit = YearWidth'(YEAR_MAX);
   localparam logic [COUNT_WIDTH-1:0] CountLimit =
      (COUNT_MAX >= 4095) ? {COUNT_WIDTH{1'b1}} : COUNT_WIDTH'(COUNT_MAX);
   localparam logic [YearWidth-1:0] Year400 = YearWidth'(400);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SPLIT,
      ST_CHECK,
      ST_RUN
   } state_type;

   state_type               state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [DAY_WIDTH-1:0]    day_ff, day_in;
   logic [MONTH_WIDTH-1:0]  month_ff, month_in;
   logic [YearWidth-1:0]    year_ff, year_in;
   logic [YearWidth-1:0]    rem_ff, rem_in;
   logic [REM400_WIDTH-1:0] rem400_ff, rem400_in;
   logic [REM100_WIDTH-1:0] rem100_ff, rem100_in;
   logic [STEPS_WIDTH-1:0]  steps_ff, steps_in;
   logic                    month_op_ff, month_op_in;

   logic                    month_mode;
   logic [DAY_WIDTH-1:0]    step_day;
   logic [MONTH_WIDTH-1:0]  step_month;
   logic [YearWidth-1:0]    step_year;
   logic [REM400_WIDTH-1:0] step_rem400;
   logic [REM100_WIDTH-1:0] step_rem100;
   cda_step_status_type     step_status;

   logic [COUNT_WIDTH-1:0]  count_lim;
   logic [STEPS_WIDTH-1:0]  count_ext;
   logic [REM400_WIDTH-1:0] split_rem100;
   logic                    date_bad;

   assign month_mode = (state_ff == ST_RUN) && month_op_ff;

   cda_step_unit #(
      .YEAR_MAX   (YEAR_MAX),
      .YEAR_WIDTH (YearWidth)
   ) u_step (
      .month_mode  (month_mode),
      .day         (day_ff),
      .month       (month_ff),
      .year        (year_ff),
      .rem400      (rem400_ff),
      .rem100      (rem100_ff),
      .day_next    (step_day),
      .month_next  (step_month),
      .year_next   (step_year),
      .rem400_next (step_rem400),
      .rem100_next (step_rem100),
      .status      (step_status)
   );

   assign count_lim = (req_data.count > CountLimit) ? CountLimit : req_data.count;
   assign count_ext = STEPS_WIDTH'(count_lim);

   // The remainder modulo 400 is below 400, so three compares give it modulo 100.
   always_comb begin
      priority if (rem_ff[REM400_WIDTH-1:0] >= 9'd300) begin
         split_rem100 = rem_ff[REM400_WIDTH-1:0] - 9'd300;
      end else if (rem_ff[REM400_WIDTH-1:0] >= 9'd200) begin
         split_rem100 = rem_ff[REM400_WIDTH-1:0] - 9'd200;
      end else if (rem_ff[REM400_WIDTH-1:0] >= 9'd100) begin
         split_rem100 = rem_ff[REM400_WIDTH-1:0] - 9'd100;
      end else begin
         split_rem100 = rem_ff[REM400_WIDTH-1:0];
      end
   end

   assign date_bad = (month_ff < MONTH_JAN) || (month_ff > MONTH_DEC) ||
                     (year_ff == '0) || (year_ff > YearLimit) ||
                     (day_ff == '0) || (day_ff > step_status.month_len);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      rem_in       = rem_ff;
      rem400_in    = rem400_ff;
      rem100_in    = rem100_ff;
      steps_in     = steps_ff;
      month_op_in  = month_op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               day_in      = req_data.start_day;
               month_in    = req_data.start_month;
               year_in     = YearWidth'(req_data.start_year);
               rem_in      = YearWidth'(req_data.start_year);
               month_op_in = (req_data.op == OP_ADD_MONTHS);
               unique case (req_data.op)
                  OP_ADD_DAYS:   steps_in = count_ext;
                  OP_ADD_WEEKS:  steps_in = (count_ext << 3) - count_ext;
                  OP_ADD_MONTHS: steps_in = count_ext;
                  default:       steps_in = '0;
               endcase
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (rem_ff >= Year400) begin
               rem_in = rem_ff - Year400;
            end else begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            rem400_in = rem_ff[REM400_WIDTH-1:0];
            rem100_in = split_rem100[REM100_WIDTH-1:0];
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (date_bad) begin
               rsp_in.end_day   = day_ff;
               rsp_in.end_month = month_ff;
               rsp_in.end_year  = year_ff[YEAR_BITS-1:0];
               rsp_in.status    = STATUS_BAD_DATE;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (steps_ff == '0) begin
               rsp_in.end_day   = day_ff;
               rsp_in.end_month = month_ff;
               rsp_in.end_year  = year_ff[YEAR_BITS-1:0];
               rsp_in.status    = STATUS_OK;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end else if (step_status.year_over) begin
               rsp_in.end_day   = 5'd31;
               rsp_in.end_month = MONTH_DEC;
               rsp_in.end_year  = YearLimit[YEAR_BITS-1:0];
               rsp_in.status    = STATUS_SATURATED;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               day_in    = step_day;
               month_in  = step_month;
               year_in   = step_year;
               rem400_in = step_rem400;
               rem100_in = step_rem100;
               steps_in  = steps_ff - STEPS_WIDTH'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff      <= rsp_in;
      day_ff      <= day_in;
      month_ff    <= month_in;
      year_ff     <= year_in;
      rem_ff      <= rem_in;
      rem400_ff   <= rem400_in;
      rem100_ff   <= rem100_in;
      steps_ff    <= steps_in;
      month_op_ff <= month_op_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/cda_step_unit.sv =====
module cda_step_unit #(
   parameter int YEAR_MAX   = 9999,
   parameter int YEAR_WIDTH = 14
) (
   input  logic                                   month_mode,
   input  logic [cda_pkg::DAY_WIDTH-1:0]          day,
   input  logic [cda_pkg::MONTH_WIDTH-1:0]        month,
   input  logic [YEAR_WIDTH-1:0]                  year,
   input  logic [cda_pkg::REM400_WIDTH-1:0]       rem400,
   input  logic [cda_pkg::REM100_WIDTH-1:0]       rem100,
   output logic [cda_pkg::DAY_WIDTH-1:0]          day_next,
   output logic [cda_pkg::MONTH_WIDTH-1:0]        month_next,
   output logic [YEAR_WIDTH-1:0]                  year_next,
   output logic [cda_pkg::REM400_WIDTH-1:0]       rem400_next,
   output logic [cda_pkg::REM100_WIDTH-1:0]       rem100_next,
   output cda_pkg::cda_step_status_type           status
);
   import cda_pkg::*;

   localparam logic [YEAR_WIDTH-1:0]   YearLimit = YEAR_WIDTH'(YEAR_MAX);
   localparam logic [REM400_WIDTH-1:0] Rem400Top = 9'd399;
   localparam logic [REM100_WIDTH-1:0] Rem100Top = 7'd99;

   logic                   leap;
   logic                   at_limit;
   logic [MONTH_WIDTH-1:0] month_inc;
   logic [MONTH_WIDTH-1:0] len_month;
   logic [DAY_WIDTH-1:0]   len;
   logic [REM400_WIDTH-1:0] rem400_inc;
   logic [REM100_WIDTH-1:0] rem100_inc;

   // Leap year from the low year bits and the running remainders.
   assign leap = ((year[1:0] == 2'd0) && (rem100 != '0)) || (rem400 == '0);
   assign at_limit = (year >= YearLimit);
   assign month_inc = (month < MONTH_DEC) ? month + 4'd1 : MONTH_JAN;
   // A month step clamps against the month being entered; January's length
   // does not depend on the year, so the current leap flag serves.
   assign len_month = month_mode ? month_inc : month;
   assign len = month_days(len_month, leap);
   assign rem400_inc = (rem400 == Rem400Top) ? '0 : rem400 + 9'd1;
   assign rem100_inc = (rem100 == Rem100Top) ? '0 : rem100 + 7'd1;

   always_comb begin
      day_next         = day;
      month_next       = month;
      year_next        = year;
      rem400_next      = rem400;
      rem100_next      = rem100;
      status.year_over = 1'b0;
      status.month_len = len;
      if (month_mode) begin
         if (month < MONTH_DEC) begin
            month_next = month_inc;
         end else if (at_limit) begin
            status.year_over = 1'b1;
         end else begin
            month_next  = MONTH_JAN;
            year_next   = year + YEAR_WIDTH'(1);
            rem400_next = rem400_inc;
            rem100_next = rem100_inc;
         end
         if (day > len) begin
            day_next = len;
         end
      end else begin
         if (day < len) begin
            day_next = day + 5'd1;
         end else if (month < MONTH_DEC) begin
            day_next   = 5'd1;
            month_next = month_inc;
         end else if (at_limit) begin
            status.year_over = 1'b1;
         end else begin
            day_next    = 5'd1;
            month_next  = MONTH_JAN;
            year_next   = year + YEAR_WIDTH'(1);
            rem400_next = rem400_inc;
            rem100_next = rem100_inc;
         end
      end
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import cda_pkg::*;

   localparam int COUNT_LIMIT = 4095;
   localparam int YEAR_LIMIT = 9999;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 150000;
   localparam int DRAIN_CYCLES = 64;
   localparam int IDLE_PERCENT = 36;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   req_type pending_requests[$];
   req_type issued_requests[$];
   rsp_type expected_dates[$];

   int requests_taken = 0;
   int results_seen = 0;
   int saturated_seen = 0;
   int bad_dates_seen = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;

   calendar_date_adder #(
      .COUNT_MAX(COUNT_LIMIT),
      .YEAR_MAX (YEAR_LIMIT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always #10 clock = ~clock;

   function automatic int unsigned days_of_month(input int unsigned mon,
                                                 input int unsigned yr);
      bit leap;
      leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      case (mon)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // Walks the date one day or one month at a time, the way the block does.
   function automatic rsp_type predict_date_sum(input req_type r);
      int unsigned day, mon, yr, cnt, steps, i;
      logic [1:0]  st;
      rsp_type     res;
      day = r.start_day;
      mon = r.start_month;
      yr = r.start_year;
      cnt = r.count;
      st = STATUS_OK;
      if (cnt > COUNT_LIMIT) cnt = COUNT_LIMIT;
      if (mon < 1 || mon > 12 || yr < 1 || yr > YEAR_LIMIT ||
          day < 1 || day > days_of_month(mon, yr)) begin
         st = STATUS_BAD_DATE;
      end else if (r.op == OP_ADD_DAYS || r.op == OP_ADD_WEEKS) begin
         steps = (r.op == OP_ADD_WEEKS) ? cnt * 7 : cnt;
         for (i = 0; i < steps && st == STATUS_OK; i++) begin
            if (day < days_of_month(mon, yr)) begin
               day++;
            end else if (mon < MONTH_DEC) begin
               day = 1;
               mon++;
            end else if (yr >= YEAR_LIMIT) begin
               st = STATUS_SATURATED;
            end else begin
               day = 1;
               mon = MONTH_JAN;
               yr++;
            end
         end
      end else if (r.op == OP_ADD_MONTHS) begin
         for (i = 0; i < cnt && st == STATUS_OK; i++) begin
            if (mon < MONTH_DEC) begin
               mon++;
            end else if (yr >= YEAR_LIMIT) begin
               st = STATUS_SATURATED;
            end else begin
               mon = MONTH_JAN;
               yr++;
            end
            // The clamp carries into later steps.
            if (st == STATUS_OK && day > days_of_month(mon, yr)) day = days_of_month(mon, yr);
         end
      end
      if (st == STATUS_SATURATED) begin
         day = 31;
         mon = MONTH_DEC;
         yr = YEAR_LIMIT;
      end
      res.end_day = 5'(day);
      res.end_month = 4'(mon);
      res.end_year = 14'(yr);
      res.status = st;
      return res;
   endfunction

   task automatic add_request(input logic [1:0] op, input int count, input int day,
                              input int mon, input int yr);
      req_type r;
      r.op = op;
      r.count = 12'(count);
      r.start_day = 5'(day);
      r.start_month = 4'(mon);
      r.start_year = 14'(yr);
      pending_requests.push_back(r);
   endtask

   // Request driver: idles at random except for a stretch in the middle of the run where it never idles.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            issued_requests.push_back(req_data);
            expected_dates.push_back(predict_date_sum(req_data));
            requests_taken++;
         end
         if (!start || !busy) begin
            if (pending_requests.size() != 0 &&
                ((requests_taken >= 40 && requests_taken < 70) ||
                 $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               req_data <= pending_requests.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      req_type req_seen;
      rsp_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_dates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: %0d-%0d-%0d status %0d", rsp_data.end_year,
                        rsp_data.end_month, rsp_data.end_day, rsp_data.status);
         end else begin
            req_seen = issued_requests.pop_front();
            want = expected_dates.pop_front();
            if (want.status == STATUS_SATURATED) saturated_seen++;
            if (want.status == STATUS_BAD_DATE) bad_dates_seen++;
            if (rsp_data.end_day !== want.end_day || rsp_data.end_month !== want.end_month ||
                rsp_data.end_year !== want.end_year || rsp_data.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: op %0d count %0d from %0d-%0d-%0d: expected ",
                            "%0d-%0d-%0d status %0d, got %0d-%0d-%0d status %0d"},
                           req_seen.op, req_seen.count, req_seen.start_year,
                           req_seen.start_month, req_seen.start_day, want.end_year,
                           want.end_month, want.end_day, want.status, rsp_data.end_year,
                           rsp_data.end_month, rsp_data.end_day, rsp_data.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no request or result for %0d cycles", WATCHDOG_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int          pick, mon, yr, len, cnt;
      int          total_requests;
      logic [1:0]  op;
      // Leap rules, rollovers and clamps.
      add_request(OP_ADD_DAYS, 1, 28, 2, 2000);
      add_request(OP_ADD_DAYS, 1, 28, 2, 1900);
      add_request(OP_ADD_DAYS, 1, 31, 12, 2023);
      add_request(OP_ADD_DAYS, 1, 29, 2, 2024);
      add_request(OP_ADD_MONTHS, 1, 31, 1, 2024);
      add_request(OP_ADD_MONTHS, 2, 31, 1, 2023);
      add_request(OP_ADD_MONTHS, 1, 15, 12, 2023);
      add_request(OP_ADD_WEEKS, 3, 10, 3, 2021);
      // Year saturation, and a zero count on the top date.
      add_request(OP_ADD_DAYS, 1, 31, 12, 9999);
      add_request(OP_ADD_MONTHS, 7, 15, 6, 9999);
      add_request(OP_ADD_WEEKS, 4095, 1, 1, 9990);
      add_request(OP_ADD_MONTHS, 0, 31, 12, 9999);
      // Longest walks from the first year.
      add_request(OP_ADD_WEEKS, 4095, 1, 1, 1);
      add_request(OP_ADD_MONTHS, 4095, 31, 1, 1);
      add_request(OP_ADD_DAYS, 4095, 1, 1, 1);
      // Zero count and the unused operation.
      add_request(OP_ADD_DAYS, 0, 5, 5, 2020);
      add_request(OP_UNUSED, 100, 5, 5, 2020);
      // Bad dates.
      add_request(OP_ADD_DAYS, 1, 1, 0, 2000);
      add_request(OP_ADD_WEEKS, 1, 1, 13, 2000);
      add_request(OP_ADD_DAYS, 5, 0, 6, 2000);
      add_request(OP_ADD_MONTHS, 1, 31, 4, 2000);
      add_request(OP_ADD_DAYS, 1, 29, 2, 2023);
      add_request(OP_ADD_DAYS, 1, 1, 1, 0);
      add_request(OP_ADD_DAYS, 1, 1, 1, 10000);
      add_request(OP_ADD_MONTHS, 4095, 31, 15, 16383);

      // Mostly valid dates, biased toward month ends, centuries and the first and last years.
      repeat (75) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) cnt = $urandom_range(0, 40);
         else if (pick < 92) cnt = $urandom_range(0, 1023);
         else cnt = $urandom_range(0, 4095);
         if ($urandom_range(0, 99) < 15) begin
            add_request(2'($urandom_range(0, 3)), cnt, $urandom_range(0, 31),
                        $urandom_range(0, 15), $urandom_range(0, 16383));
         end else begin
            op = ($urandom_range(0, 99) < 5) ? OP_UNUSED : 2'($urandom_range(0, 2));
            pick = $urandom_range(0, 99);
            if (pick < 60) yr = $urandom_range(1, YEAR_LIMIT);
            else if (pick < 75) yr = $urandom_range(YEAR_LIMIT - 19, YEAR_LIMIT);
            else if (pick < 90) yr = $urandom_range(1, 99) * 100;
            else yr = $urandom_range(1, 10);
            mon = $urandom_range(1, 12);
            len = days_of_month(mon, yr);
            add_request(op, cnt, ($urandom_range(0, 3) == 0) ? len - $urandom_range(0, 1)
                                                              : $urandom_range(1, len),
                        mon, yr);
         end
      end
      total_requests = pending_requests.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (results_seen < total_requests)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests and %0d results", requests_taken, results_seen);
      $display("of which %0d saturated the year and %0d carried a bad date",
               saturated_seen, bad_dates_seen);
      if (mismatch_count == 0 && expected_dates.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
